// ===== hw/rtl/fttp_pkg.sv =====
`timescale 1ns / 1ps
// fttp_pkg: constants, widths and codes for the time-to-target predictor
// no dependencies; used by flow_time_to_target_predictor, fttp_checker and tb_top
package fttp_pkg;

  // ring depth and derived index width
  localparam int CAPACITY = 16;
  localparam int LG       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // field widths
  localparam int TW  = 32;               // timestamp
  localparam int WW  = 24;               // weight
  localparam int QW  = 32;               // predicted time

  // accumulator and product widths
  localparam int NW   = LG + 1;          // entry count
  localparam int SXW  = TW + LG;         // sum of x
  localparam int SYW  = WW + LG;         // sum of y
  localparam int SXXW = 2 * TW + LG;     // sum of x*x
  localparam int SXYW = TW + WW + LG;    // sum of x*y
  localparam int NAW  = SXYW + NW;       // n * sxy
  localparam int NBW  = SXW + SYW;       // sx * sy
  localparam int DAW  = SXXW + NW;       // n * sxx
  localparam int DBW  = 2 * SXW;         // sx * sx
  localparam int DFW  = WW + 1;          // target minus weight
  localparam int PW   = DAW + DFW;       // final product and remainder
  localparam int MBW  = SXW;             // widest multiplier operand b

  // actions
  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_PREDICT = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_ARM     = 2'd3;

  // result status
  localparam logic [1:0] ST_NOT_READY = 2'd0;
  localparam logic [1:0] ST_REACHED   = 2'd1;
  localparam logic [1:0] ST_NO_RATE   = 2'd2;
  localparam logic [1:0] ST_PREDICTED = 2'd3;

  // register map
  localparam int          ADDR_W        = 3;
  localparam logic [0:0]  REG_TARGET    = 1'b0;
  localparam logic [WW-1:0] TARGET_RESET = 24'd3600;

endpackage

// ===== hw/rtl/flow_time_to_target_predictor.sv =====
`timescale 1ns / 1ps
// flow_time_to_target_predictor: reading ring, least-squares slope, time to target
// depends on fttp_pkg
//
// Keeps the last CAPACITY (time, weight) readings in a ring memory with one
// write and one read port. Add, clear and arm requests give no result. A
// predict request gives one result. When the ring is not full or the block is
// not armed it goes straight to the result; otherwise it reads the newest entry,
// walks the ring entry by entry (S_RD, S_MUL, S_ACC) through the memory read
// port and two multipliers, forms four products and one final product on a
// shared shift-add multiplier (one bit of the short operand per cycle, up to its
// highest set bit), then runs a 32-step restoring divider, one quotient bit per
// cycle.
// Requests are taken one at a time; a finished result waits in the output
// register while the next request is accepted. The ring needs no clearing pass:
// a prediction only reads it once every entry has been written.
module flow_time_to_target_predictor (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [fttp_pkg::TW-1:0]     timestamp,
  input  logic signed [fttp_pkg::WW-1:0] weight,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [fttp_pkg::QW-1:0]     predicted_time,
  output logic                        ready_res,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fttp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fttp_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CUR    = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_MLOAD  = 4'd5;
  localparam logic [3:0] S_MRUN   = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_DIVCHK = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam logic [LG-1:0] LAST_SLOT = LG'(CAPACITY - 1);

  logic [3:0]        state;
  logic [LG-1:0]     write_slot;
  logic              ring_full;
  logic              ready_flag;
  logic [WW-1:0]     target_weight;

  // ring memory, {time, weight}
  logic [TW+WW-1:0]  ring_mem [CAPACITY];
  logic [TW+WW-1:0]  rd_data;
  logic [LG-1:0]     rd_addr;
  logic              wr_en;

  // scan registers
  logic [LG-1:0]     scan_idx;
  logic [TW-1:0]     x_r;
  logic [WW-1:0]     y_r;
  logic [2*TW-1:0]   xx_r;
  logic [TW+WW-1:0]  xy_r;
  logic              nz_r;
  logic [NW-1:0]     n_cnt;
  logic [SXW-1:0]    sx;
  logic [SYW-1:0]    sy;
  logic [SXXW-1:0]   sxx;
  logic [SXYW-1:0]   sxy;
  logic [DFW-1:0]    diff;

  // products and shared multiplier / divider
  logic [2:0]        mstep;
  logic [NAW-1:0]    num_a;
  logic [NBW-1:0]    num_b;
  logic [DAW-1:0]    den_a;
  logic [DBW-1:0]    den_b;
  logic [PW-1:0]     mul_acc;
  logic [PW-1:0]     mul_a;
  logic [MBW-1:0]    mul_b;
  logic [4:0]        div_cnt;

  // pending result
  logic [1:0]        res_status;
  logic [QW-1:0]     res_time;

  logic              in_fire;
  logic              cfg_wr;
  logic [LG-1:0]     last_slot;
  logic              div_ge;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_TARGET);
  assign prdata    = (paddr[ADDR_W-1] == REG_TARGET) ?
                     {{(32-WW){target_weight[WW-1]}}, target_weight} : 32'd0;
  assign last_slot = (write_slot == '0) ? LAST_SLOT : write_slot - LG'(1);
  assign wr_en     = in_fire && (action == ACT_ADD);
  assign rd_addr   = (state == S_IDLE) ? last_slot : scan_idx;
  assign div_ge    = (mul_acc >= mul_a);

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[write_slot] <= {timestamp, weight};
    end
    rd_data <= ring_mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_weight <= TARGET_RESET;
    end else if (cfg_wr) begin
      target_weight <= pwdata[WW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status         <= res_status;
      predicted_time <= res_time;
      ready_res      <= ready_flag;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      ring_full  <= 1'b0;
      ready_flag <= 1'b1;
      mstep      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (action)
              ACT_ADD: begin
                write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + LG'(1);
                if (write_slot == LAST_SLOT) begin
                  ring_full <= 1'b1;
                end
              end
              ACT_PREDICT: begin
                if (!ring_full || !ready_flag) begin
                  state <= S_DONE;
                end else begin
                  state <= S_CUR;
                end
              end
              ACT_CLEAR: begin
                write_slot <= '0;
                ring_full  <= 1'b0;
                ready_flag <= 1'b0;
              end
              default: begin
                ready_flag <= 1'b1;
              end
            endcase
          end
        end
        S_CUR: begin
          if ($signed(rd_data[WW-1:0]) >= $signed(target_weight)) begin
            state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (scan_idx == LAST_SLOT) begin
            state <= S_MLOAD;
            mstep <= '0;
          end else begin
            state <= S_RD;
          end
        end
        S_MLOAD: state <= S_MRUN;
        S_MRUN: begin
          if (mul_b == '0) begin
            case (mstep)
              3'd3:    state <= S_CHK;
              3'd4:    state <= S_DIVCHK;
              default: state <= S_MLOAD;
            endcase
            mstep <= mstep + 3'd1;
          end
        end
        S_CHK: begin
          if ((num_a <= NAW'(num_b)) || (den_a <= DAW'(den_b))) begin
            state <= S_DONE;
          end else begin
            state <= S_MLOAD;
            mstep <= 3'd4;
          end
        end
        S_DIVCHK: begin
          if (mul_acc >= PW'({num_a, 32'd0})) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: scan, products, division
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_status <= ST_NOT_READY;
        res_time   <= '0;
        scan_idx   <= '0;
        n_cnt      <= '0;
        sx         <= '0;
        sy         <= '0;
        sxx        <= '0;
        sxy        <= '0;
      end
      S_CUR: begin
        res_status <= ST_REACHED;
        diff <= {target_weight[WW-1], target_weight} -
                {rd_data[WW-1], rd_data[WW-1:0]};
      end
      S_MUL: begin
        // y is the weight offset to unsigned by flipping its sign bit
        x_r  <= rd_data[TW+WW-1:WW];
        y_r  <= {~rd_data[WW-1], rd_data[WW-2:0]};
        xx_r <= rd_data[TW+WW-1:WW] * rd_data[TW+WW-1:WW];
        xy_r <= rd_data[TW+WW-1:WW] * {~rd_data[WW-1], rd_data[WW-2:0]};
        nz_r <= (rd_data[TW+WW-1:WW] != '0);
      end
      S_ACC: begin
        if (nz_r) begin
          n_cnt <= n_cnt + NW'(1);
          sx    <= sx + SXW'(x_r);
          sy    <= sy + SYW'(y_r);
          sxx   <= sxx + SXXW'(xx_r);
          sxy   <= sxy + SXYW'(xy_r);
        end
        scan_idx <= scan_idx + LG'(1);
      end
      S_MLOAD: begin
        mul_acc <= '0;
        case (mstep)
          3'd0: begin
            mul_a <= PW'(sxy);
            mul_b <= MBW'(n_cnt);
          end
          3'd1: begin
            mul_a <= PW'(sx);
            mul_b <= MBW'(sy);
          end
          3'd2: begin
            mul_a <= PW'(sxx);
            mul_b <= MBW'(n_cnt);
          end
          3'd3: begin
            mul_a <= PW'(sx);
            mul_b <= sx;
          end
          default: begin
            mul_a <= PW'(den_a - DAW'(den_b));
            mul_b <= MBW'(diff);
          end
        endcase
      end
      S_MRUN: begin
        // shift-add, one bit of the short operand per cycle
        if (mul_b == '0) begin
          case (mstep)
            3'd0:    num_a <= mul_acc[NAW-1:0];
            3'd1:    num_b <= mul_acc[NBW-1:0];
            3'd2:    den_a <= mul_acc[DAW-1:0];
            3'd3:    den_b <= mul_acc[DBW-1:0];
            default: ;
          endcase
        end else begin
          if (mul_b[0]) begin
            mul_acc <= mul_acc + mul_a;
          end
          mul_a <= {mul_a[PW-2:0], 1'b0};
          mul_b <= {1'b0, mul_b[MBW-1:1]};
        end
      end
      S_CHK: begin
        res_status <= ST_NO_RATE;
        num_a      <= num_a - NAW'(num_b);
      end
      S_DIVCHK: begin
        // quotient overflow saturates, else restoring division
        res_status <= ST_PREDICTED;
        res_time   <= '1;
        mul_a      <= PW'({num_a, 31'd0});
        div_cnt    <= 5'd31;
      end
      S_DIV: begin
        if (div_ge) begin
          mul_acc <= mul_acc - mul_a;
        end
        res_time <= {res_time[QW-2:0], div_ge};
        mul_a    <= {1'b0, mul_a[PW-1:1]};
        div_cnt  <= div_cnt - 5'd1;
      end
      default: ;
    endcase
  end

  // clear drops both flags
  a_clear_flags: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_CLEAR |=> !ring_full && !ready_flag)
    else $error("clear did not drop ring_full and ready_flag");

  // a predict while not armed or not full gives status 0 without scanning
  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_PREDICT && (!ring_full || !ready_flag)
    |=> state == S_DONE && res_status == ST_NOT_READY)
    else $error("unready predict did not finish at once");

  // only a predicted status carries a time
  a_time_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PREDICTED |-> predicted_time == '0)
    else $error("time non-zero without prediction");

  // product step stays within the sequence
  a_mstep: assert property (@(posedge clk) disable iff (rst)
    state == S_MRUN || state == S_MLOAD |-> mstep <= 3'd4)
    else $error("product step out of range");

endmodule

// ===== verif/fttp_checker.sv =====
`timescale 1ns / 1ps
// fttp_checker: watches the request, result and configuration traffic of the
// time-to-target predictor, predicts each result and compares it; needs fttp_pkg
module fttp_checker
  import fttp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        action,
  input  logic [TW-1:0]     timestamp,
  input  logic [WW-1:0]     weight,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        status,
  input  logic [QW-1:0]     predicted_time,
  input  logic              ready_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [1:0]    st;
    logic [QW-1:0] eta;
    logic          armed;
  } forecast_t;

  forecast_t           forecasts[$];
  logic signed [WW-1:0] wring[CAPACITY];
  logic [TW-1:0]        tring[CAPACITY];
  logic [LG-1:0]        slot;
  logic                 full;
  logic                 armed;
  logic signed [WW-1:0] goal;

  assign pending = forecasts.size();

  // least-squares time to target over the current ring
  function automatic forecast_t forecast();
    forecast_t f;
    logic [LG-1:0] last;
    logic signed [WW-1:0] cur;
    logic [127:0] sx, sy, sxx, sxy, n, x, y, na, nb, da, db, q;
    f.armed = armed;
    f.eta = '0;
    last = slot - 1'b1;
    cur = wring[last];
    sx = 0; sy = 0; sxx = 0; sxy = 0; n = 0;
    if (!full || !armed) begin
      f.st = ST_NOT_READY;
      return f;
    end
    if (cur >= goal) begin
      f.st = ST_REACHED;
      return f;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (tring[i] != 0) begin
        x = {96'b0, tring[i]};
        y = {104'b0, wring[i] ^ 24'h800000};
        sx += x; sy += y; sxx += x * x; sxy += x * y; n += 1;
      end
    end
    na = n * sxy; nb = sx * sy; da = n * sxx; db = sx * sx;
    if (na <= nb || da <= db) begin
      f.st = ST_NO_RATE;
      return f;
    end
    q = ({{104{1'b0}}, 24'(goal - cur)} * (da - db)) / (na - nb);
    f.st = ST_PREDICTED;
    f.eta = (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    return f;
  endfunction

  always @(posedge clk) begin
    forecast_t e;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        wring[i] = '0; tring[i] = '0;
      end
      slot = '0; full = 1'b0; armed = 1'b1; goal = TARGET_RESET;
      errors = 0;
      forecasts.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready && paddr == ADDR_W'(REG_TARGET))
        goal = pwdata[WW-1:0];
      // results, checked before this edge's request is applied
      if (out_valid && out_ready) begin
        if (forecasts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result st=%0d t=%0d rdy=%0b", $time, status,
                   predicted_time, ready_res);
        end else begin
          e = forecasts.pop_front();
          if (status !== e.st || predicted_time !== e.eta || ready_res !== e.armed) begin
            errors++;
            $display("%0t: mismatch expected st=%0d t=%0d rdy=%0b actual st=%0d t=%0d rdy=%0b",
                     $time, e.st, e.eta, e.armed, status, predicted_time, ready_res);
          end
        end
      end
      // requests
      if (in_valid && in_ready) begin
        case (action)
          ACT_ADD: begin
            wring[slot] = weight;
            tring[slot] = timestamp;
            slot = (slot == LG'(CAPACITY - 1)) ? '0 : slot + 1'b1;
            if (slot == 0) full = 1'b1;
          end
          ACT_PREDICT: forecasts.push_back(forecast());
          ACT_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) begin
              wring[i] = '0; tring[i] = '0;
            end
            slot = '0; full = 1'b0; armed = 1'b0;
          end
          default: armed = 1'b1;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for flow_time_to_target_predictor
// depends on fttp_pkg, the block and fttp_checker
module tb_top;
  import fttp_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid, in_ready;
  logic [1:0]        action;
  logic [TW-1:0]     timestamp;
  logic signed [WW-1:0] weight;
  logic              out_valid, out_ready;
  logic [1:0]        status;
  logic [QW-1:0]     predicted_time;
  logic              ready_res;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  int                errors, pending;
  bit                calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_time_to_target_predictor dut (.*);

  fttp_checker chk (.*);

  // result side stalls in bursts until the calm tail
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // one request; the valid stays high across back-to-back requests
  task automatic push(input logic [1:0] act, input logic [TW-1:0] ts,
                      input logic signed [WW-1:0] w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    timestamp <= ts;
    weight    <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain results, then leave room for a prediction still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_target(input logic signed [WW-1:0] t);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_TARGET); pwdata <= 32'(t);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // fill the ring along a line with random noise
  task automatic ramp(input int count, input int step, input int rate, input int noise,
                      input int base);
    logic [TW-1:0] ts;
    ts = $urandom_range(1, 100000);
    for (int i = 0; i < count; i++) begin
      push(ACT_ADD, ts, WW'(base + rate * i + $signed($urandom_range(0, 2 * noise)) - noise));
      ts += $urandom_range(1, step);
      if ($urandom_range(0, 3) == 0) push(ACT_PREDICT, $urandom, WW'($urandom));
    end
  endtask

  initial begin
    logic signed [WW-1:0] goals[6];
    int kind;
    goals = '{24'sd3600, -24'sd8388608, 24'sd8388607, 24'sd0, 24'sd20000, -24'sd500};
    rst <= 1'b1;
    in_valid <= 1'b0; action <= ACT_ADD; timestamp <= '0; weight <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, rising line, reached target, flat, zero spread, clear/arm
    push(ACT_PREDICT, '1, '1);
    for (int i = 0; i < CAPACITY; i++) push(ACT_ADD, 32'(1000 + 100 * i), WW'(10 * i));
    push(ACT_PREDICT, '0, '0);
    push(ACT_ADD, 32'hFFFFFFFF, 24'sh7FFFFF);
    push(ACT_PREDICT, '0, '0);
    push(ACT_ADD, 32'd5, -24'sd8388608);
    push(ACT_PREDICT, '0, '0);
    push(ACT_CLEAR, '1, '1);
    push(ACT_PREDICT, '0, '0);
    push(ACT_ARM, '0, '0);
    for (int i = 0; i < CAPACITY; i++) push(ACT_ADD, 32'd777, WW'(i));
    push(ACT_PREDICT, '0, '0);
    for (int i = 0; i < CAPACITY; i++) push(ACT_ADD, (i == 3) ? 32'd0 : 32'(9000 - i), -24'sd9);
    push(ACT_PREDICT, '0, '0);
    settle();
    set_target(24'sd8388607);
    push(ACT_CLEAR, '0, '0);
    push(ACT_ARM, '0, '0);
    for (int i = 0; i < CAPACITY; i++) push(ACT_ADD, 32'(1 + 300000000 * i), WW'(-8388000 + i));
    push(ACT_PREDICT, '0, '0);
    settle();

    // random phases, one target per phase
    for (int ph = 0; ph < 6; ph++) begin
      set_target(goals[ph]);
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < 12; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          if ($urandom_range(0, 1)) push(ACT_CLEAR, $urandom, WW'($urandom));
          push(ACT_ARM, $urandom, WW'($urandom));
          ramp($urandom_range(CAPACITY, CAPACITY + 6), $urandom_range(1, 5000),
               $signed($urandom_range(0, 60)) - 10, $urandom_range(0, 40),
               int'(goals[ph]) - $urandom_range(0, 3000));
        end else begin
          // noise: any action, any field values, zero timestamps now and then
          repeat ($urandom_range(4, 10)) begin
            push(2'($urandom), ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom,
                 WW'($urandom));
            if ($urandom_range(0, 2) == 0) push(ACT_PREDICT, '0, '0);
          end
        end
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fttp_pkg.sv
hw/rtl/flow_time_to_target_predictor.sv
verif/fttp_checker.sv
verif/tb_top.sv
